>>> rtl/core/elfnd_pkg.sv
// Shared types, codes and name tables of the note area deframer.
package elfnd_pkg;

   localparam int unsigned WORD_ALIGN = 4;
   localparam int unsigned HDR_BYTES  = 3 * WORD_ALIGN;
   localparam int unsigned NUM_NAMES  = 5;
   localparam int unsigned CSR_IDX_W  = 2;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_AREA_BYTES  = 2'd0;
   localparam csr_idx_type CSR_BIG_ENDIAN  = 2'd1;
   localparam csr_idx_type CSR_FILTER_MODE = 2'd2;

   typedef logic [2:0] role_type;
   localparam role_type ROLE_NAMESZ  = 3'd0;
   localparam role_type ROLE_DESCSZ  = 3'd1;
   localparam role_type ROLE_TYPE    = 3'd2;
   localparam role_type ROLE_NAME    = 3'd3;
   localparam role_type ROLE_DESC    = 3'd4;
   localparam role_type ROLE_IGNORED = 3'd5;

   typedef logic [2:0] handler_type;
   localparam handler_type HND_NONE       = 3'd0;
   localparam handler_type HND_VMCORE     = 3'd1;
   localparam handler_type HND_HV_VMCORE  = 3'd2;
   localparam handler_type HND_PRSTATUS   = 3'd3;
   localparam handler_type HND_CRASH_INFO = 3'd4;
   localparam handler_type HND_VERSION    = 3'd5;
   localparam handler_type HND_HEADER     = 3'd6;
   localparam handler_type HND_FORMAT     = 3'd7;

   typedef logic [1:0] stop_type;
   localparam stop_type STOP_NONE  = 2'd0;
   localparam stop_type STOP_SHORT = 2'd1;
   localparam stop_type STOP_OVER  = 2'd2;

   typedef logic [1:0] filter_type;
   localparam filter_type FILT_NEUTRAL = 2'd0;
   localparam filter_type FILT_ARCH    = 2'd1;
   localparam filter_type FILT_BOTH    = 2'd2;

   localparam logic [31:0] TYP_PRSTATUS   = 32'h0000_0001;
   localparam logic [31:0] TYP_CRASH_INFO = 32'h0100_0001;
   localparam logic [31:0] TYP_HEADER     = 32'h0200_0001;
   localparam logic [31:0] TYP_VERSION    = 32'h0200_0002;
   localparam logic [31:0] TYP_FORMAT     = 32'h0200_0003;

   typedef enum logic [2:0] {
      PH_NAMESZ,
      PH_DESCSZ,
      PH_TYPE,
      PH_NAME,
      PH_DESC,
      PH_STOP
   } phase_type;

   typedef struct packed {
      logic [31:0] area_bytes;
      logic        big_endian;
      filter_type  filter_mode;
   } cfg_type;

   typedef struct packed {
      role_type    role;
      logic [31:0] host_word;
      logic [31:0] note_type;
      handler_type handler;
      logic        handler_valid;
      logic [31:0] payload_offset;
      logic [2:0]  payload_bytes;
      logic        payload_last;
      logic [15:0] note_index;
      stop_type    stop_reason;
   } rsp_type;

   // known names, ASCII, first character in the most significant byte
   localparam logic [127:0] NAME_STR [NUM_NAMES] = '{
      128'h564D434F5245494E464F,
      128'h564D434F5245494E464F5F58454E,
      128'h434F5245,
      128'h58656E,
      128'h2E6E6F74652E58656E
   };
   localparam logic [4:0] NAME_LEN [NUM_NAMES] = '{5'd10, 5'd14, 5'd4, 5'd3, 5'd9};

   function automatic logic [7:0] name_char(int unsigned i, logic [3:0] p);
      logic [3:0] sh;
      sh = 4'(NAME_LEN[i] - 5'd1 - {1'b0, p});
      if ({1'b0, p} < NAME_LEN[i]) begin
         return NAME_STR[i][8*sh +: 8];
      end
      return 8'h00;
   endfunction

   function automatic handler_type pick_handler(logic [NUM_NAMES-1:0] m,
                                                filter_type fm, logic [31:0] t);
      logic neutral;
      logic arch;
      neutral = (fm != FILT_ARCH);
      arch    = (fm != FILT_NEUTRAL);
      priority if (m[0] && neutral) return HND_VMCORE;
      else if (m[1] && neutral) return HND_HV_VMCORE;
      else if (m[2] && arch && t == TYP_PRSTATUS) return HND_PRSTATUS;
      else if (m[3] && arch && t == TYP_CRASH_INFO) return HND_CRASH_INFO;
      else if (m[3] && arch && t == TYP_VERSION) return HND_VERSION;
      else if (m[4] && arch && t == TYP_HEADER) return HND_HEADER;
      else if (m[4] && arch && t == TYP_FORMAT) return HND_FORMAT;
      else return HND_NONE;
   endfunction

endpackage

>>> rtl/core/elfnd_csr.sv
// Configuration registers and parse restart strobe.
module elfnd_csr
   import elfnd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  csr_idx_type csr_index,
   input  logic [31:0] csr_wdata,
   output cfg_type     cfg,
   output logic        restart
);

   logic [31:0] area_ff, area_in;
   logic        be_ff, be_in;
   filter_type  fm_ff, fm_in;
   logic        restart_ff, restart_in;

   assign csr_ready  = 1'b1;
   // restart rises in the cycle after the write, once area_ff holds the new length
   assign restart_in = csr_valid && csr_ready && csr_index == CSR_AREA_BYTES;
   assign restart    = restart_ff;

   always_comb begin
      area_in = area_ff;
      be_in   = be_ff;
      fm_in   = fm_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_AREA_BYTES:  area_in = csr_wdata;
            CSR_BIG_ENDIAN:  be_in   = csr_wdata[0];
            CSR_FILTER_MODE: fm_in   = csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         area_ff    <= '0;
         be_ff      <= 1'b0;
         fm_ff      <= FILT_BOTH;
         restart_ff <= 1'b0;
      end else begin
         area_ff    <= area_in;
         be_ff      <= be_in;
         fm_ff      <= fm_in;
         restart_ff <= restart_in;
      end
   end

   assign cfg = '{area_bytes: area_ff, big_endian: be_ff, filter_mode: fm_ff};

endmodule

>>> rtl/core/elfnd_parse.sv
// Input register and note parser: phase tracking, name match, area bookkeeping.
module elfnd_parse
   import elfnd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        restart,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_area_word,
   output logic        res_valid,
   input  logic        res_ready,
   output rsp_type     res
);

   logic              s1_valid_ff, s1_valid_in;
   logic [31:0]       s1_word_ff;
   logic              advance, take;

   phase_type         phase_ff, phase_in;
   logic [29:0]       sc_ff, sc_in;
   logic [31:0]       ns_ff, ns_in;
   logic [31:0]       ps_ff, ps_in;
   logic [31:0]       type_ff, type_in;
   logic [32:0]       bl_ff, bl_in;
   logic [34:0]       blmf_ff, blmf_in;
   logic [NUM_NAMES-1:0] match_ff, match_in;
   logic [15:0]       count_ff, count_in;
   stop_type          stop_ff, stop_in;

   logic [31:0]       raw, host;
   logic [33:0]       name_pad, pay_pad;
   logic [34:0]       blmf_calc;
   logic [32:0]       bl_new;
   logic [30:0]       words_name, words_pay, sc_inc;
   logic [31:0]       desc_off, desc_rem;
   logic [NUM_NAMES-1:0] len_match, match_byte;
   logic              short_tail, fit, ns_zero, ps_zero, name_last, desc_last, close_note;

   assign advance   = s1_valid_ff && res_ready;
   assign req_stall = s1_valid_ff && !res_ready;
   assign take      = req_valid && !req_stall;
   assign res_valid = s1_valid_ff;

   assign s1_valid_in = take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (take) begin
         s1_word_ff <= req_area_word;
      end
   end

   assign raw  = s1_word_ff;
   assign host = cfg.big_endian ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;

   assign name_pad  = ({2'b00, ns_ff} + 34'd3) & ~34'd3;
   assign pay_pad   = ({2'b00, ps_ff} + 34'd3) & ~34'd3;
   assign blmf_calc = {2'b00, bl_ff} - 35'(HDR_BYTES) - {1'b0, name_pad};
   assign fit       = !blmf_ff[34] && ({3'b000, ps_ff} <= blmf_ff);
   assign bl_new    = (blmf_ff >= {1'b0, pay_pad}) ? 33'(blmf_ff - {1'b0, pay_pad}) : '0;

   assign words_name = name_pad[32:2];
   assign words_pay  = pay_pad[32:2];
   assign sc_inc     = {1'b0, sc_ff} + 31'd1;
   assign desc_off   = {sc_ff, 2'b00};
   assign desc_rem   = ps_ff - desc_off;

   assign short_tail = bl_ff < 33'(HDR_BYTES);
   assign ns_zero    = ns_ff == '0;
   assign ps_zero    = ps_ff == '0;
   assign name_last  = sc_inc >= words_name;
   assign desc_last  = sc_inc >= words_pay;
   assign close_note = (phase_ff == PH_TYPE && fit && ns_zero && ps_zero)
                    || (phase_ff == PH_NAME && name_last && ps_zero)
                    || (phase_ff == PH_DESC && desc_last);

   always_comb begin
      for (int i = 0; i < NUM_NAMES; i++) begin
         len_match[i] = ns_ff == {27'd0, NAME_LEN[i]} || ns_ff == {27'd0, NAME_LEN[i]} + 32'd1;
      end
   end

   // four bytes per word against every known name
   always_comb begin
      logic [31:0] pos;
      match_byte = match_ff;
      for (int k = 0; k < 4; k++) begin
         pos = {sc_ff, 2'(k)};
         if (pos < ns_ff) begin
            for (int i = 0; i < NUM_NAMES; i++) begin
               if (sc_ff >= 30'd4 || name_char(i, pos[3:0]) != raw[8*k +: 8]) begin
                  match_byte[i] = 1'b0;
               end
            end
         end
      end
   end

   // next phase
   always_comb begin
      unique case (phase_ff)
         PH_NAMESZ: phase_in = short_tail ? PH_STOP : PH_DESCSZ;
         PH_DESCSZ: phase_in = PH_TYPE;
         PH_TYPE: begin
            priority if (!fit) phase_in = PH_STOP;
            else if (!ns_zero) phase_in = PH_NAME;
            else if (!ps_zero) phase_in = PH_DESC;
            else phase_in = PH_NAMESZ;
         end
         PH_NAME: begin
            priority if (!name_last) phase_in = PH_NAME;
            else if (ps_zero) phase_in = PH_NAMESZ;
            else phase_in = PH_DESC;
         end
         PH_DESC:  phase_in = desc_last ? PH_NAMESZ : PH_DESC;
         PH_STOP:  phase_in = PH_STOP;
         default:  phase_in = PH_STOP;
      endcase
   end

   // result and datapath
   always_comb begin
      sc_in    = sc_ff;
      ns_in    = ns_ff;
      ps_in    = ps_ff;
      type_in  = type_ff;
      bl_in    = bl_ff;
      blmf_in  = blmf_ff;
      match_in = match_ff;
      count_in = count_ff;
      stop_in  = stop_ff;
      res                = '0;
      res.role           = ROLE_IGNORED;
      res.host_word      = host;
      res.note_index     = count_ff;
      unique case (phase_ff)
         PH_NAMESZ: begin
            if (short_tail) begin
               stop_in = STOP_SHORT;
            end else begin
               ns_in    = host;
               res.role = ROLE_NAMESZ;
            end
         end
         PH_DESCSZ: begin
            ps_in    = host;
            blmf_in  = blmf_calc;
            match_in = len_match;
            res.role = ROLE_DESCSZ;
         end
         PH_TYPE: begin
            type_in       = host;
            res.role      = ROLE_TYPE;
            res.note_type = host;
            if (!fit) begin
               stop_in = STOP_OVER;
            end else begin
               bl_in = bl_new;
               sc_in = '0;
               if (ns_zero) begin
                  res.handler_valid = 1'b1;
                  res.handler       = pick_handler(match_ff, cfg.filter_mode, host);
               end
            end
         end
         PH_NAME: begin
            res.role      = ROLE_NAME;
            res.note_type = type_ff;
            match_in      = match_byte;
            sc_in         = sc_inc[29:0];
            if (name_last) begin
               res.handler_valid = 1'b1;
               res.handler       = pick_handler(match_byte, cfg.filter_mode, type_ff);
               sc_in             = '0;
            end
         end
         PH_DESC: begin
            res.role           = ROLE_DESC;
            res.note_type      = type_ff;
            res.handler_valid  = 1'b1;
            res.handler        = pick_handler(match_ff, cfg.filter_mode, type_ff);
            res.payload_offset = desc_off;
            res.payload_bytes  = (desc_rem >= 32'd4) ? 3'd4 : desc_rem[2:0];
            sc_in              = sc_inc[29:0];
         end
         PH_STOP: ;
         default: ;
      endcase
      if (close_note) begin
         res.payload_last = 1'b1;
         sc_in            = '0;
         if (count_ff != 16'hFFFF) begin
            count_in = count_ff + 16'd1;
         end
      end
      res.stop_reason = stop_in;
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         phase_ff <= PH_NAMESZ;
         sc_ff    <= '0;
         ns_ff    <= '0;
         ps_ff    <= '0;
         type_ff  <= '0;
         bl_ff    <= reset ? 33'd0 : {1'b0, cfg.area_bytes};
         blmf_ff  <= '0;
         match_ff <= '1;
         count_ff <= '0;
         stop_ff  <= STOP_NONE;
      end else if (advance) begin
         phase_ff <= phase_in;
         sc_ff    <= sc_in;
         ns_ff    <= ns_in;
         ps_ff    <= ps_in;
         type_ff  <= type_in;
         bl_ff    <= bl_in;
         blmf_ff  <= blmf_in;
         match_ff <= match_in;
         count_ff <= count_in;
         stop_ff  <= stop_in;
      end
   end

endmodule

>>> rtl/core/elfnd_outreg.sv
// Result register towards the response channel.
module elfnd_outreg
   import elfnd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    res_valid,
   output logic    res_ready,
   input  rsp_type res,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   logic    valid_ff, valid_in;
   rsp_type rsp_ff;

   assign res_ready = !valid_ff || !rsp_stall;
   assign valid_in  = res_ready ? res_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (res_ready && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> rtl/core/elf_note_deframer.sv
// Top level of the note area deframer.
// Each item passes the input register and then the result register; one item per cycle
// unless rsp_stall holds the result register. Per-note state is updated as each item leaves
// the input register, with the area fit check split over the descriptor size and type words.
// Reset: synchronous, clears the channels, configuration to its defaults and the parse state.
// A write to area_bytes sets the registered restart strobe, which then resets the parse state.
module elf_note_deframer
   import elfnd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_area_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_role,
   output logic [31:0] rsp_host_word,
   output logic [31:0] rsp_note_type,
   output logic [2:0]  rsp_handler,
   output logic        rsp_handler_valid,
   output logic [31:0] rsp_payload_offset,
   output logic [2:0]  rsp_payload_bytes,
   output logic        rsp_payload_last,
   output logic [15:0] rsp_note_index,
   output logic [1:0]  rsp_stop_reason,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type cfg;
   logic    restart;
   logic    res_valid, res_ready;
   rsp_type res, rsp;

   elfnd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .restart   (restart)
   );

   elfnd_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .restart       (restart),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_area_word (req_area_word),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .res           (res)
   );

   elfnd_outreg u_outreg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_role           = rsp.role;
   assign rsp_host_word      = rsp.host_word;
   assign rsp_note_type      = rsp.note_type;
   assign rsp_handler        = rsp.handler;
   assign rsp_handler_valid  = rsp.handler_valid;
   assign rsp_payload_offset = rsp.payload_offset;
   assign rsp_payload_bytes  = rsp.payload_bytes;
   assign rsp_payload_last   = rsp.payload_last;
   assign rsp_note_index     = rsp.note_index;
   assign rsp_stop_reason    = rsp.stop_reason;

endmodule

>>> rtl/core/elfnd_checker.sv
// Port-level checks of the note area deframer, bound to the top level.
module elfnd_checker
   import elfnd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_role,
   input logic [31:0] rsp_host_word,
   input logic [2:0]  rsp_handler,
   input logic        rsp_handler_valid,
   input logic [2:0]  rsp_payload_bytes,
   input logic        rsp_payload_last,
   input logic [1:0]  rsp_stop_reason
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_role) && $stable(rsp_host_word))
      else $error("stalled item changed");

   a_handler: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_handler != HND_NONE |-> rsp_handler_valid)
      else $error("handler code without handler_valid");

   a_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_bytes != 3'd0 |-> rsp_role == ROLE_DESC)
      else $error("payload bytes outside descriptor");

   a_ignored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_role == ROLE_IGNORED |-> rsp_stop_reason != STOP_NONE)
      else $error("ignored word while parsing");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_last |-> rsp_handler_valid &&
         (rsp_role == ROLE_TYPE || rsp_role == ROLE_NAME || rsp_role == ROLE_DESC))
      else $error("note closed on a header or ignored item");

endmodule

bind elf_note_deframer elfnd_checker u_elfnd_checker (.*);

>>> tb/tb_elf_note_deframer.sv
// Self-checking testbench for the note area deframer: random note streams against a tag predictor.
module tb_elf_note_deframer;
   timeunit 1ns;
   timeprecision 1ps;
   import elfnd_pkg::*;

   localparam int unsigned ITEM_TARGET = 1550;
   localparam csr_idx_type CSR_SPARE   = 2'd3;

   // known names, first character in bits 7:0
   localparam logic [127:0] KNOWN_NAME [NUM_NAMES] = '{
      128'h4F46_4E49_4552_4F43_4D56,
      128'h4E45_585F_4F46_4E49_4552_4F43_4D56,
      128'h4552_4F43,
      128'h6E_6558,
      128'h6E_6558_2E65_746F_6E2E
   };
   localparam int unsigned KNOWN_LEN [NUM_NAMES] = '{10, 14, 4, 3, 9};

   function automatic logic [63:0] pad4(logic [63:0] n);
      return (n + 64'd3) & ~64'd3;
   endfunction

   class tag_tracker;
      rsp_type     tagged_q[$];
      int unsigned errors;
      int unsigned checked;
      logic [31:0] area_cfg;
      logic        be_cfg;
      filter_type  filt_cfg;
      phase_type   ph;
      logic [63:0] word_cnt;
      logic [63:0] nsz;
      logic [63:0] dsz;
      logic [63:0] left;
      logic [31:0] ntype;
      logic [4:0]  match;
      logic [15:0] notes;
      stop_type    stop;

      function void restart();
         ph       = PH_NAMESZ;
         word_cnt = '0;
         nsz      = '0;
         dsz      = '0;
         ntype    = '0;
         left     = {32'd0, area_cfg};
         match    = '1;
         notes    = '0;
         stop     = STOP_NONE;
      endfunction

      function void power_on();
         area_cfg = '0;
         be_cfg   = 1'b0;
         filt_cfg = FILT_BOTH;
         errors   = 0;
         checked  = 0;
         restart();
      endfunction

      function void write_reg(csr_idx_type idx, logic [31:0] d);
         case (idx)
            CSR_AREA_BYTES: begin
               area_cfg = d;
               restart();
            end
            CSR_BIG_ENDIAN:  be_cfg = d[0];
            CSR_FILTER_MODE: filt_cfg = d[1:0];
            default: ;
         endcase
      endfunction

      function handler_type select_handler();
         logic neu;
         logic arc;
         neu = (filt_cfg != FILT_ARCH);
         arc = (filt_cfg != FILT_NEUTRAL);
         if (match[0] && neu) return HND_VMCORE;
         if (match[1] && neu) return HND_HV_VMCORE;
         if (match[2] && arc && ntype == TYP_PRSTATUS) return HND_PRSTATUS;
         if (match[3] && arc) begin
            if (ntype == TYP_CRASH_INFO) return HND_CRASH_INFO;
            if (ntype == TYP_VERSION) return HND_VERSION;
         end
         if (match[4] && arc) begin
            if (ntype == TYP_HEADER) return HND_HEADER;
            if (ntype == TYP_FORMAT) return HND_FORMAT;
         end
         return HND_NONE;
      endfunction

      function void end_note();
         if (notes != 16'hFFFF) notes++;
         ph       = PH_NAMESZ;
         word_cnt = '0;
      endfunction

      function void take_area_word(logic [31:0] raw);
         rsp_type     e;
         logic [31:0] host;
         logic [63:0] front;
         logic [63:0] dpad;
         logic [63:0] pos;
         logic [63:0] off;
         logic [63:0] rem;
         host = be_cfg ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
         e = '0;
         e.role       = ROLE_IGNORED;
         e.host_word  = host;
         e.note_index = notes;
         case (ph)
            PH_NAMESZ: begin
               if (left < HDR_BYTES) begin
                  stop = STOP_SHORT;
                  ph   = PH_STOP;
               end else begin
                  nsz    = {32'd0, host};
                  e.role = ROLE_NAMESZ;
                  ph     = PH_DESCSZ;
               end
            end
            PH_DESCSZ: begin
               dsz    = {32'd0, host};
               e.role = ROLE_DESCSZ;
               ph     = PH_TYPE;
            end
            PH_TYPE: begin
               front       = HDR_BYTES + pad4(nsz);
               dpad        = pad4(dsz);
               ntype       = host;
               e.role      = ROLE_TYPE;
               e.note_type = host;
               if (front + dsz > left) begin
                  stop = STOP_OVER;
                  ph   = PH_STOP;
               end else begin
                  left  = left - front;
                  left  = (left >= dpad) ? left - dpad : 64'd0;
                  match = '0;
                  for (int i = 0; i < NUM_NAMES; i++) begin
                     if (nsz == KNOWN_LEN[i] || nsz == KNOWN_LEN[i] + 1) match[i] = 1'b1;
                  end
                  word_cnt = '0;
                  if (nsz != 0) begin
                     ph = PH_NAME;
                  end else begin
                     e.handler_valid = 1'b1;
                     e.handler       = select_handler();
                     if (dsz != 0) begin
                        ph = PH_DESC;
                     end else begin
                        e.payload_last = 1'b1;
                        end_note();
                     end
                  end
               end
            end
            PH_NAME: begin
               e.role      = ROLE_NAME;
               e.note_type = ntype;
               for (int k = 0; k < 4; k++) begin
                  pos = word_cnt * 4 + k;
                  if (pos < nsz) begin
                     for (int i = 0; i < NUM_NAMES; i++) begin
                        if (pos >= 16 || KNOWN_NAME[i][8*pos[3:0] +: 8] != raw[8*k +: 8])
                           match[i] = 1'b0;
                     end
                  end
               end
               word_cnt++;
               if (word_cnt >= (pad4(nsz) >> 2)) begin
                  e.handler_valid = 1'b1;
                  e.handler       = select_handler();
                  word_cnt        = '0;
                  if (dsz != 0) begin
                     ph = PH_DESC;
                  end else begin
                     e.payload_last = 1'b1;
                     end_note();
                  end
               end
            end
            PH_DESC: begin
               off              = word_cnt * 4;
               rem              = (off < dsz) ? dsz - off : 64'd0;
               e.role           = ROLE_DESC;
               e.note_type      = ntype;
               e.handler_valid  = 1'b1;
               e.handler        = select_handler();
               e.payload_offset = off[31:0];
               e.payload_bytes  = (rem >= 4) ? 3'd4 : rem[2:0];
               word_cnt++;
               if (word_cnt >= (pad4(dsz) >> 2)) begin
                  e.payload_last = 1'b1;
                  end_note();
               end
            end
            default: ;
         endcase
         e.stop_reason = stop;
         tagged_q.push_back(e);
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch: %s", msg);
      endtask

      task cmp(string f, logic [31:0] g, logic [31:0] w);
         if (g !== w) report($sformatf("item %0d %s: got %h, want %h", checked, f, g, w));
      endtask

      task check_tagged_word(rsp_type got);
         rsp_type e;
         if (tagged_q.size() == 0) begin
            report($sformatf("item with nothing pending, role %0d word %h",
                             got.role, got.host_word));
            return;
         end
         e = tagged_q.pop_front();
         checked++;
         cmp("role", got.role, e.role);
         cmp("host_word", got.host_word, e.host_word);
         cmp("note_type", got.note_type, e.note_type);
         cmp("handler", got.handler, e.handler);
         cmp("handler_valid", got.handler_valid, e.handler_valid);
         cmp("payload_offset", got.payload_offset, e.payload_offset);
         cmp("payload_bytes", got.payload_bytes, e.payload_bytes);
         cmp("payload_last", got.payload_last, e.payload_last);
         cmp("note_index", got.note_index, e.note_index);
         cmp("stop_reason", got.stop_reason, e.stop_reason);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_area_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_role;
   logic [31:0] rsp_host_word;
   logic [31:0] rsp_note_type;
   logic [2:0]  rsp_handler;
   logic        rsp_handler_valid;
   logic [31:0] rsp_payload_offset;
   logic [2:0]  rsp_payload_bytes;
   logic        rsp_payload_last;
   logic [15:0] rsp_note_index;
   logic [1:0]  rsp_stop_reason;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   csr_idx_type csr_index = '0;
   logic [31:0] csr_wdata = '0;

   tag_tracker  tracker;
   int unsigned words_sent = 0;
   int unsigned burst_left = 0;
   logic        cur_be = 1'b0;
   logic [63:0] room = '0;
   bit          parse_done = 1'b0;
   int unsigned stall_left = 0;
   int unsigned stall_pct = 0;

   elf_note_deframer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_area_word      (req_area_word),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_role           (rsp_role),
      .rsp_host_word      (rsp_host_word),
      .rsp_note_type      (rsp_note_type),
      .rsp_handler        (rsp_handler),
      .rsp_handler_valid  (rsp_handler_valid),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_payload_bytes  (rsp_payload_bytes),
      .rsp_payload_last   (rsp_payload_last),
      .rsp_note_index     (rsp_note_index),
      .rsp_stop_reason    (rsp_stop_reason),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: stretches of differing stall density, including none
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_pct  = $urandom_range(0, 3) * 30;
         stall_left = $urandom_range(10, 80);
      end
      stall_left--;
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin : monitor
      rsp_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got = '{role: rsp_role, host_word: rsp_host_word, note_type: rsp_note_type,
                 handler: rsp_handler, handler_valid: rsp_handler_valid,
                 payload_offset: rsp_payload_offset, payload_bytes: rsp_payload_bytes,
                 payload_last: rsp_payload_last, note_index: rsp_note_index,
                 stop_reason: rsp_stop_reason};
         tracker.check_tagged_word(got);
      end
   end

   function automatic logic [31:0] mem_order(logic [31:0] x);
      return cur_be ? {x[7:0], x[15:8], x[23:16], x[31:24]} : x;
   endfunction

   task put_word(input logic [31:0] w);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_area_word <= w;
      do @(posedge clock); while (req_stall);
      tracker.take_area_word(w);
      words_sent++;
   endtask

   task csr_write(input csr_idx_type idx, input logic [31:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(idx, d);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task settle();
      req_valid <= 1'b0;
      while (tracker.tagged_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task configure(input logic be, input filter_type fm, input logic [31:0] area);
      logic [31:0] r;
      cur_be = be;
      r      = $urandom;
      r[0]   = be;
      csr_write(CSR_BIG_ENDIAN, r);
      r      = $urandom;
      r[1:0] = fm;
      csr_write(CSR_FILTER_MODE, r);
      csr_write(CSR_AREA_BYTES, area);
      room       = {32'd0, area};
      parse_done = 1'b0;
   endtask

   // one note; an oversized one stops after its type word, a truncated one ends the pass
   task send_note(input logic [31:0] nsz, input logic [31:0] dsz, input logic [31:0] typ,
                  input int sel, input bit corrupt);
      logic [63:0] front;
      logic [31:0] w;
      int unsigned nw;
      int unsigned dw;
      int unsigned cut;
      int unsigned bad;
      int unsigned pos;
      front = HDR_BYTES + pad4(nsz);
      put_word(mem_order(nsz));
      put_word(mem_order(dsz));
      put_word(mem_order(typ));
      if (front + dsz > room) begin
         parse_done = 1'b1;
         return;
      end
      room = room - front;
      room = (room >= pad4(dsz)) ? room - pad4(dsz) : 64'd0;
      nw   = 32'(pad4(nsz) >> 2);
      dw   = 32'(pad4(dsz) >> 2);
      cut  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, nw + dw) : nw + dw;
      if (cut < nw + dw) parse_done = 1'b1;
      bad = (corrupt && nsz != 0) ? $urandom_range(0, nsz - 1) : 32'hFFFF_FFFF;
      for (int i = 0; i < cut; i++) begin
         w = $urandom;
         if (i < nw) begin
            for (int k = 0; k < 4; k++) begin
               pos = 4 * i + k;
               if (pos < nsz && sel < NUM_NAMES)
                  w[8*k +: 8] = (pos < KNOWN_LEN[sel]) ? KNOWN_NAME[sel][8*pos +: 8] : 8'h00;
               if (pos == bad) w[8*k +: 8] = w[8*k +: 8] ^ (8'h01 << $urandom_range(0, 7));
            end
         end
         put_word(w);
      end
   endtask

   task random_note();
      logic [31:0] nsz;
      logic [31:0] dsz;
      logic [31:0] typ;
      logic [63:0] front;
      logic [63:0] maxd;
      int          sel;
      int          r;
      r   = $urandom_range(0, 99);
      sel = $urandom_range(0, NUM_NAMES + 1);
      if (sel < NUM_NAMES) nsz = KNOWN_LEN[sel] + $urandom_range(0, 1);
      else if (sel == NUM_NAMES) nsz = 0;
      else nsz = $urandom_range(1, 20);
      front = HDR_BYTES + pad4(nsz);
      if (front > room) begin
         nsz   = 0;
         sel   = NUM_NAMES;
         front = HDR_BYTES;
      end
      maxd = room - front;
      if (maxd > 40) maxd = 40;
      dsz = ($urandom_range(0, 3) == 0) ? 32'(maxd) : $urandom_range(0, 32'(maxd));
      case ($urandom_range(0, 6))
         0: typ = TYP_PRSTATUS;
         1: typ = TYP_CRASH_INFO;
         2: typ = TYP_HEADER;
         3: typ = TYP_VERSION;
         4: typ = TYP_FORMAT;
         5: typ = $urandom;
         default: typ = $urandom_range(0, 3);
      endcase
      if (r < 3) nsz = 32'hFFFF_FFFF;
      else if (r < 6) dsz = 32'hFFFF_FFFF;
      else if (r < 9) dsz = 32'(room - front + $urandom_range(1, 8));
      send_note(nsz, dsz, typ, sel, $urandom_range(0, 6) == 0);
   endtask

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int          kind;
      int unsigned notes_left;
      logic [31:0] area;
      tracker = new();
      tracker.power_on();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset state: empty area, so a short tail and then ignored words
      put_word(32'h0000_0000);
      put_word(32'hFFFF_FFFF);
      settle();

      csr_write(CSR_SPARE, 32'hFFFF_FFFF);
      configure(1'b0, FILT_BOTH, 32'd200);
      send_note(0, 0, 32'h0, NUM_NAMES, 1'b0);
      send_note(0, 5, TYP_PRSTATUS, NUM_NAMES, 1'b0);
      send_note(5, 4, TYP_PRSTATUS, 2, 1'b0);
      send_note(32'hFFFF_FFFF, 0, TYP_HEADER, NUM_NAMES + 1, 1'b0);
      settle();

      // descriptor padding runs past the area end
      configure(1'b1, FILT_ARCH, 32'd19);
      send_note(3, 3, TYP_CRASH_INFO, 3, 1'b0);
      put_word($urandom);
      settle();

      while (words_sent < ITEM_TARGET) begin
         kind = $urandom_range(0, 19);
         case (kind)
            0: area = 32'd0;
            1: area = 32'hFFFF_FFFF;
            2: area = $urandom;
            3: area = $urandom_range(0, 40);
            default: area = $urandom_range(12, 400);
         endcase
         configure(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), area);
         if (kind == 3 && $urandom_range(0, 1) == 0) csr_write(CSR_SPARE, $urandom);
         if (kind == 2 || kind == 3) begin
            repeat ($urandom_range(4, 30)) put_word($urandom);
         end else begin
            notes_left = $urandom_range(1, 12);
            while (!parse_done && room >= HDR_BYTES && notes_left != 0) begin
               random_note();
               notes_left--;
            end
            repeat ($urandom_range(0, 3)) put_word($urandom);
         end
         settle();
      end

      settle();
      if (tracker.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
